// ----- rtl/bblur_pkg.sv -----
// ----------------------------------------------------------------------------
// bblur_pkg
// Shared widths, constants and types of the 3x3 clamped box blur.
// ----------------------------------------------------------------------------
package bblur_pkg;

  localparam int PixW     = 8;
  localparam int CfgW     = 11;
  localparam int CoordW   = 10;
  localparam int ColSumW  = 10;
  localparam int SumW     = 12;
  localparam int RegAddrW = 3;
  localparam int DataW    = 32;
  localparam int LineW    = 2 * PixW;
  localparam int NumSlots = 4;
  localparam int WinSize  = 9;

  // floor(s / 9) == (s * 7282) >> 16 for every s below 9 * 256
  localparam int                RecipW     = 13;
  localparam logic [RecipW-1:0] RecipNine  = 13'd7282;
  localparam int                RecipShift = 16;
  localparam int                ProdW      = SumW + RecipW;

  localparam logic [CfgW-1:0] SizeReset = 11'd1024;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [SumW-1:0]   sum;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic              eof;
  } res_slot_t;

  typedef struct packed {
    logic [NumSlots-1:0]      valid;
    res_slot_t [NumSlots-1:0] slot;
  } res_bundle_t;

endpackage

// ----- rtl/bblur_line_mem.sv -----
// ----------------------------------------------------------------------------
// bblur_line_mem
// Line store: one word per column holding the row above and the row two
// above. One read and one write port, registered read data.
// ----------------------------------------------------------------------------
module bblur_line_mem #(
  parameter int Depth = 1024,
  parameter int AddrW = 10
) (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [AddrW-1:0]            rd_addr_i,
  output logic [bblur_pkg::LineW-1:0] rd_data_o,
  input  logic                        wr_en_i,
  input  logic [AddrW-1:0]            wr_addr_i,
  input  logic [bblur_pkg::LineW-1:0] wr_data_i
);

  logic [bblur_pkg::LineW-1:0] mem_q [Depth];
  logic [bblur_pkg::LineW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/bblur_window.sv -----
// ----------------------------------------------------------------------------
// bblur_window
// 3x3 window registers and clamped neighborhood sums for the up to four
// results that one pixel releases.
// ----------------------------------------------------------------------------
module bblur_window #(
  parameter int ColW = 10,
  parameter int RowW = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       shift_i,
  input  logic [bblur_pkg::PixW-1:0] pix_i,
  input  logic [bblur_pkg::PixW-1:0] prev_i,
  input  logic [bblur_pkg::PixW-1:0] older_i,
  input  logic [ColW-1:0]            col_i,
  input  logic [RowW-1:0]            row_i,
  input  logic                       last_col_i,
  input  logic                       last_row_i,
  output bblur_pkg::res_bundle_t     bundle_o
);

  localparam int PixW    = bblur_pkg::PixW;
  localparam int ColSumW = bblur_pkg::ColSumW;
  localparam int SumW    = bblur_pkg::SumW;
  localparam int CoordW  = bblur_pkg::CoordW;
  localparam int WinSize = bblur_pkg::WinSize;

  logic [PixW-1:0]    win_q [WinSize];
  logic [PixW-1:0]    win_d [WinSize];
  logic [ColSumW-1:0] up    [3];
  logic [ColSumW-1:0] lo    [3];
  logic               r_zero, r_one, c_zero, c_one;
  logic [ColW-1:0]    col_m1;
  logic [RowW-1:0]    row_m1;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      win_d[i] = win_q[i+3];
    end
    win_d[6] = older_i;
    win_d[7] = prev_i;
    win_d[8] = pix_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WinSize; i++) begin
        win_q[i] <= '0;
      end
    end else if (shift_i) begin
      for (int i = 0; i < WinSize; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  assign r_zero = (row_i == '0);
  assign r_one  = (row_i == RowW'(1));
  assign c_zero = (col_i == '0);
  assign c_one  = (col_i == ColW'(1));
  assign col_m1 = col_i - ColW'(1);
  assign row_m1 = row_i - RowW'(1);

  // column sums: upper pass clamps top on row 1, lower pass clamps bottom (and top on row 0)
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      up[k] = ColSumW'(r_one ? win_d[3*k+1] : win_d[3*k])
            + ColSumW'(win_d[3*k+1]) + ColSumW'(win_d[3*k+2]);
      lo[k] = ColSumW'(r_zero ? win_d[3*k+2] : win_d[3*k+1])
            + (ColSumW'(win_d[3*k+2]) << 1);
    end
  end

  always_comb begin
    bundle_o.valid[0] = !r_zero && !c_zero;
    bundle_o.valid[1] = !r_zero && last_col_i;
    bundle_o.valid[2] = last_row_i && !c_zero;
    bundle_o.valid[3] = last_row_i && last_col_i;

    bundle_o.slot[0].sum = SumW'(c_one ? up[1] : up[0]) + SumW'(up[1]) + SumW'(up[2]);
    bundle_o.slot[0].col = CoordW'(col_m1);
    bundle_o.slot[0].row = CoordW'(row_m1);
    bundle_o.slot[0].eof = 1'b0;

    bundle_o.slot[1].sum = SumW'(c_zero ? up[2] : up[1]) + (SumW'(up[2]) << 1);
    bundle_o.slot[1].col = CoordW'(col_i);
    bundle_o.slot[1].row = CoordW'(row_m1);
    bundle_o.slot[1].eof = 1'b0;

    bundle_o.slot[2].sum = SumW'(c_one ? lo[1] : lo[0]) + SumW'(lo[1]) + SumW'(lo[2]);
    bundle_o.slot[2].col = CoordW'(col_m1);
    bundle_o.slot[2].row = CoordW'(row_i);
    bundle_o.slot[2].eof = 1'b0;

    bundle_o.slot[3].sum = SumW'(c_zero ? lo[2] : lo[1]) + (SumW'(lo[2]) << 1);
    bundle_o.slot[3].col = CoordW'(col_i);
    bundle_o.slot[3].row = CoordW'(row_i);
    bundle_o.slot[3].eof = 1'b1;
  end

endmodule

// ----- rtl/bblur_out.sv -----
// ----------------------------------------------------------------------------
// bblur_out
// Result bundle register, divide by nine and output register. Drains one
// result per cycle in slot order unless the output is stalled.
// ----------------------------------------------------------------------------
module bblur_out (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  bblur_pkg::res_bundle_t       bundle_i,
  output logic                         free_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [bblur_pkg::PixW-1:0]   blurred_value_o,
  output logic [bblur_pkg::CoordW-1:0] out_col_o,
  output logic [bblur_pkg::CoordW-1:0] out_row_o,
  output logic                         last_of_run_o,
  output logic                         end_of_frame_o
);

  localparam int NumSlots = bblur_pkg::NumSlots;
  localparam int ProdW    = bblur_pkg::ProdW;
  localparam int PixW     = bblur_pkg::PixW;
  localparam int CoordW   = bblur_pkg::CoordW;

  logic [NumSlots-1:0]                 mask_q, mask_d, mask_left;
  bblur_pkg::res_slot_t [NumSlots-1:0] slot_q;
  logic [$clog2(NumSlots)-1:0]         sel;
  bblur_pkg::res_slot_t                pick;
  logic [ProdW-1:0]                    prod;
  logic                                take, pop;

  logic              out_valid_q, out_valid_d;
  logic [PixW-1:0]   value_q;
  logic [CoordW-1:0] col_q, row_q;
  logic              last_q, eof_q;

  always_comb begin
    if (mask_q[0]) begin
      sel = 2'd0;
    end else if (mask_q[1]) begin
      sel = 2'd1;
    end else if (mask_q[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
  end

  assign pick      = slot_q[sel];
  assign prod      = ProdW'(pick.sum) * ProdW'(bblur_pkg::RecipNine);
  assign take      = !out_valid_q || out_ready_i;
  assign pop       = take && (mask_q != '0);
  assign mask_left = mask_q & ~(NumSlots'(1) << sel);
  assign free_o    = (mask_q == '0) || (pop && (mask_left == '0));

  always_comb begin
    mask_d = mask_q;
    if (pop) begin
      mask_d = mask_left;
    end
    if (load_i) begin
      mask_d = bundle_i.valid;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= bundle_i.slot;
    end
    if (pop) begin
      value_q <= prod[bblur_pkg::RecipShift +: PixW];
      col_q   <= pick.col;
      row_q   <= pick.row;
      last_q  <= (mask_left == '0);
      eof_q   <= pick.eof;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign blurred_value_o = value_q;
  assign out_col_o       = col_q;
  assign out_row_o       = row_q;
  assign last_of_run_o   = last_q;
  assign end_of_frame_o  = eof_q;

endmodule

// ----- rtl/box_blur_3x3_clamped.sv -----
// ----------------------------------------------------------------------------
// box_blur_3x3_clamped
// Streaming 3x3 box blur with edge clamping; results tagged with their
// coordinates and released as soon as their neighborhood is complete.
// ----------------------------------------------------------------------------
//   channel   handshake                   payload
//   in        in_valid_i / in_ready_o     pixel_value_i
//   out       out_valid_o / out_ready_i   blurred_value_o, out_col_o, out_row_o,
//                                         last_of_run_o, end_of_frame_o
//   cfg       APB psel/penable/pwrite     image_width @0x0, image_height @0x4
//
// One pixel per cycle while the output keeps up, set by the line store port
// (read at accept, write as the item leaves the read stage). Results pass the
// read stage, bundle and output registers. A ready output drains one result per
// cycle; last-column (two results) and last-row (up to four) pixels stall input.
// Reset clears control, counters and the window; the line store is not cleared.
// ----------------------------------------------------------------------------
module box_blur_3x3_clamped #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bblur_pkg::PixW-1:0]     pixel_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bblur_pkg::PixW-1:0]     blurred_value_o,
  output logic [bblur_pkg::CoordW-1:0]   out_col_o,
  output logic [bblur_pkg::CoordW-1:0]   out_row_o,
  output logic                           last_of_run_o,
  output logic                           end_of_frame_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bblur_pkg::RegAddrW-1:0] paddr,
  input  logic [bblur_pkg::DataW-1:0]    pwdata,
  output logic [bblur_pkg::DataW-1:0]    prdata,
  output logic                           pready
);

  localparam int PixW   = bblur_pkg::PixW;
  localparam int CfgW   = bblur_pkg::CfgW;
  localparam int LineW  = bblur_pkg::LineW;
  localparam int DataW  = bblur_pkg::DataW;
  localparam int ColW   = $clog2(MAX_WIDTH);
  localparam int RowW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WCmpW  = ($clog2(MAX_WIDTH + 1) > CfgW) ? $clog2(MAX_WIDTH + 1) : CfgW;
  localparam int HCmpW  = ($clog2(MAX_HEIGHT + 1) > CfgW) ? $clog2(MAX_HEIGHT + 1) : CfgW;

  // configuration
  logic [CfgW-1:0]  image_width_q, image_height_q;
  logic             cfg_wr;
  logic [WCmpW-1:0] width_eff;
  logic [HCmpW-1:0] height_eff;

  // position counters
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            last_c, last_r;

  // read stage
  logic             s1_valid_q;
  logic [PixW-1:0]  s1_pix_q;
  logic [ColW-1:0]  s1_col_q;
  logic [RowW-1:0]  s1_row_q;
  logic             s1_lc_q, s1_lr_q;
  logic             fwd_q;
  logic [LineW-1:0] fwd_data_q;

  logic             accept, advance, bundle_free;
  logic [LineW-1:0] mem_rd, line_rd, line_wr;

  bblur_pkg::res_bundle_t bundle;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= bblur_pkg::SizeReset;
      image_height_q <= bblur_pkg::SizeReset;
    end else if (cfg_wr) begin
      case (bblur_pkg::reg_idx_e'(paddr[2]))
        bblur_pkg::REG_IMAGE_WIDTH:  image_width_q  <= pwdata[CfgW-1:0];
        bblur_pkg::REG_IMAGE_HEIGHT: image_height_q <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (bblur_pkg::reg_idx_e'(paddr[2]))
      bblur_pkg::REG_IMAGE_WIDTH:  prdata = DataW'(image_width_q);
      bblur_pkg::REG_IMAGE_HEIGHT: prdata = DataW'(image_height_q);
      default:                     prdata = '0;
    endcase
  end

  // zero acts as one, oversize saturates
  always_comb begin
    if (image_width_q == '0) begin
      width_eff = WCmpW'(1);
    end else if (WCmpW'(image_width_q) > WCmpW'(MAX_WIDTH)) begin
      width_eff = WCmpW'(MAX_WIDTH);
    end else begin
      width_eff = WCmpW'(image_width_q);
    end
    if (image_height_q == '0) begin
      height_eff = HCmpW'(1);
    end else if (HCmpW'(image_height_q) > HCmpW'(MAX_HEIGHT)) begin
      height_eff = HCmpW'(MAX_HEIGHT);
    end else begin
      height_eff = HCmpW'(image_height_q);
    end
  end

  assign last_c = (WCmpW'(col_q) + WCmpW'(1)) >= width_eff;
  assign last_r = (HCmpW'(row_q) + HCmpW'(1)) >= height_eff;

  always_comb begin
    col_d = col_q + ColW'(1);
    row_d = row_q;
    if (last_c) begin
      col_d = '0;
      row_d = last_r ? '0 : row_q + RowW'(1);
    end
  end

  assign advance    = s1_valid_q && bundle_free;
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  // word layout: {row above, row two above}
  assign line_rd = fwd_q ? fwd_data_q : mem_rd;
  assign line_wr = {s1_pix_q, line_rd[LineW-1:PixW]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
        // same column written back this edge: bypass the store
        fwd_q <= advance && (col_q == s1_col_q);
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q   <= pixel_value_i;
      s1_col_q   <= col_q;
      s1_row_q   <= row_q;
      s1_lc_q    <= last_c;
      s1_lr_q    <= last_r;
      fwd_data_q <= line_wr;
    end
  end

  bblur_line_mem #(
    .Depth (MAX_WIDTH),
    .AddrW (ColW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (mem_rd),
    .wr_en_i   (advance),
    .wr_addr_i (s1_col_q),
    .wr_data_i (line_wr)
  );

  bblur_window #(
    .ColW (ColW),
    .RowW (RowW)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_i    (advance),
    .pix_i      (s1_pix_q),
    .prev_i     (line_rd[LineW-1:PixW]),
    .older_i    (line_rd[PixW-1:0]),
    .col_i      (s1_col_q),
    .row_i      (s1_row_q),
    .last_col_i (s1_lc_q),
    .last_row_i (s1_lr_q),
    .bundle_o   (bundle)
  );

  bblur_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (advance),
    .bundle_i        (bundle),
    .free_o          (bundle_free),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .blurred_value_o (blurred_value_o),
    .out_col_o       (out_col_o),
    .out_row_o       (out_row_o),
    .last_of_run_o   (last_of_run_o),
    .end_of_frame_o  (end_of_frame_o)
  );

`ifndef SYNTH
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_col_q) && $stable(s1_pix_q))
    else $error("read stage item lost while stalled");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_frame_o |-> last_of_run_o)
    else $error("frame end not on last result of its item");

  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_c |=> col_q == '0)
    else $error("column counter did not wrap at row end");
`endif

endmodule
